[src/drt_pkg.sv]
// device registry table package: table geometry, operation and result codes,
// request and result payloads, and the controller/datapath command structs
// no dependencies
`timescale 1ns / 1ps

package drt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_RES     = 63;
    localparam int CNT_W       = $clog2(MAX_RES + 1);
    localparam int ID_W        = 32;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_GET_BIND  = 3'd1,
        OP_DEL_ID    = 3'd2,
        OP_DEL_BIND  = 3'd3,
        OP_PRESENT   = 3'd4,
        OP_GET_ALIVE = 3'd5,
        OP_SET_ALIVE = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_REMOVED = 2'd1,
        EV_ROSE    = 2'd2
    } t_event;

    typedef struct packed {
        logic [2:0]      operation;
        logic [ID_W-1:0] dev_id;
        logic [ID_W-1:0] bind_id;
        logic            alive_in;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [5:0]      slot;
        logic [ID_W-1:0] bind_value;
        logic            alive_value;
        logic [1:0]      event_res;
        logic [ID_W-1:0] event_id;
        logic            last;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] bound;
        logic            alive;
        logic            heard;
    } t_entry;

    // which result the datapath loads into its output register
    typedef enum logic [2:0] {
        EM_HIT,
        EM_NOT_FOUND,
        EM_FULL,
        EM_PEND,
        EM_PEND_LAST
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  step;
        logic  wr;
        logic  emit;
        t_emit kind;
        logic  take;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       bind_hit;
        logic       free;
        logic       at_end;
        logic       at_top;
        logic       pend;
        logic       cnt_full;
        logic       out_free;
    } t_sts;

endpackage

[src/drt_req_if.sv]
// request channel of the device registry table: valid, ready and payload
// depends on drt_pkg
`timescale 1ns / 1ps

interface drt_req_if import drt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/drt_res_if.sv]
// result channel of the device registry table: valid, ready and payload
// depends on drt_pkg
`timescale 1ns / 1ps

interface drt_res_if import drt_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/drt_ctrl.sv]
// device registry table controller: sequences the slot scan of each request
// depends on drt_pkg
`timescale 1ns / 1ps

module drt_ctrl import drt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                unique case (i_sts.op)
                    OP_ADD: begin
                        if (i_sts.free) begin
                            if (i_sts.out_free) begin
                                o_cmd.wr   = 1'b1;
                                o_cmd.emit = 1'b1;
                                o_cmd.kind = EM_HIT;
                                n_state    = S_IDLE;
                            end
                        end else if (i_sts.at_top) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.kind = EM_FULL;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    OP_GET_BIND, OP_PRESENT, OP_GET_ALIVE, OP_DEL_ID, OP_SET_ALIVE: begin
                        if (i_sts.at_end) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.kind = EM_NOT_FOUND;
                                n_state    = S_IDLE;
                            end
                        end else if (i_sts.hit) begin
                            if (i_sts.out_free) begin
                                o_cmd.wr   = (i_sts.op == OP_DEL_ID) ||
                                             (i_sts.op == OP_SET_ALIVE);
                                o_cmd.emit = 1'b1;
                                o_cmd.kind = EM_HIT;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    OP_DEL_BIND: begin
                        if (i_sts.at_end) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.kind = i_sts.pend ? EM_PEND_LAST : EM_NOT_FOUND;
                                n_state    = S_IDLE;
                            end
                        end else if (!i_sts.free && (i_sts.hit || i_sts.bind_hit)) begin
                            // one removal is held back so the final one can carry last
                            if (i_sts.pend && !i_sts.cnt_full) begin
                                if (i_sts.out_free) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.kind = EM_PEND;
                                    o_cmd.take = 1'b1;
                                    o_cmd.wr   = 1'b1;
                                    o_cmd.step = 1'b1;
                                end
                            end else begin
                                o_cmd.take = !i_sts.pend;
                                o_cmd.wr   = 1'b1;
                                o_cmd.step = 1'b1;
                            end
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = EM_NOT_FOUND;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/drt_dp.sv]
// device registry table datapath: slot memory with valid bits, scan pointer,
// high-water mark, held-back removal and the result register
// depends on drt_pkg and drt_res_if
`timescale 1ns / 1ps

module drt_dp import drt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req_data,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    drt_res_if.source         o_res
);

    t_entry                   r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_valid;
    t_entry                   r_rdata;
    logic                     r_rvalid;

    logic [2:0]               r_op;
    logic [ID_W-1:0]          r_dev;
    logic [ID_W-1:0]          r_bind;
    logic                     r_alive_in;
    logic [SLOT_W-1:0]        r_addr;
    logic [SLOT_W-1:0]        n_addr;
    logic [SLOT_W-1:0]        r_hw;

    logic                     r_pend;
    logic [SLOT_W-1:0]        r_pend_slot;
    logic [ID_W-1:0]          r_pend_id;
    logic [CNT_W-1:0]         r_cnt;

    t_res                     r_out;
    t_res                     n_out;
    logic                     r_out_valid;

    t_entry                   e_cur;
    t_entry                   w_ent;
    logic                     out_free;
    logic                     rose;

    // a slot never written since reset reads as free
    assign e_cur    = r_rvalid ? r_rdata : '0;
    assign out_free = !r_out_valid || o_res.ready;
    assign rose     = (r_op == OP_SET_ALIVE) && !e_cur.alive && r_alive_in;

    assign o_sts.op       = r_op;
    assign o_sts.hit      = (e_cur.id != '0) && (e_cur.id == r_dev);
    assign o_sts.bind_hit = (e_cur.id != '0) && (e_cur.bound == r_dev);
    assign o_sts.free     = (e_cur.id == '0);
    assign o_sts.at_end   = (r_addr == '0);
    assign o_sts.at_top   = (r_addr == SLOT_W'(TABLE_DEPTH - 1));
    assign o_sts.pend     = r_pend;
    assign o_sts.cnt_full = (r_cnt == CNT_W'(MAX_RES));
    assign o_sts.out_free = out_free;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_addr = r_addr;
        if (i_cmd.load) begin
            n_addr = (i_req_data.operation == OP_ADD) ? SLOT_W'(1) : r_hw;
        end else if (i_cmd.step) begin
            n_addr = (r_op == OP_ADD) ? r_addr + SLOT_W'(1) : r_addr - SLOT_W'(1);
        end
    end

    always_comb begin
        w_ent = e_cur;
        priority if (r_op == OP_ADD) begin
            w_ent.id    = r_dev;
            w_ent.bound = r_bind;
        end else if (r_op == OP_SET_ALIVE) begin
            w_ent.alive = r_alive_in;
            w_ent.heard = e_cur.heard | r_alive_in;
        end else begin
            w_ent.id    = '0;
            w_ent.bound = '0;
        end
    end

    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        unique case (i_cmd.kind)
            EM_HIT: begin
                n_out.status      = STS_OK;
                n_out.slot        = 6'(r_addr);
                n_out.bind_value  = (r_op == OP_GET_BIND) ? e_cur.bound : '0;
                n_out.alive_value = (r_op == OP_GET_ALIVE) ? e_cur.alive : 1'b0;
                n_out.event_res   = rose ? EV_ROSE : EV_NONE;
                n_out.event_id    = rose ? r_dev : '0;
            end
            EM_NOT_FOUND: n_out.status = STS_NOT_FOUND;
            EM_FULL:      n_out.status = STS_FULL;
            EM_PEND, EM_PEND_LAST: begin
                n_out.status    = STS_OK;
                n_out.slot      = 6'(r_pend_slot);
                n_out.event_res = EV_REMOVED;
                n_out.event_id  = r_pend_id;
                n_out.last      = (i_cmd.kind == EM_PEND_LAST);
            end
            default: n_out.status = STS_NOT_FOUND;
        endcase
    end

    // memory: write at the scan slot, read the slot the scan moves to
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_addr] <= w_ent;
        end
        r_rdata <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rvalid    <= 1'b0;
            r_hw        <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_addr   <= n_addr;
            r_rvalid <= r_valid[n_addr] && !(i_cmd.wr && (n_addr == r_addr));
            if (i_cmd.wr) begin
                r_valid[r_addr] <= 1'b1;
                if ((r_op == OP_ADD) && (r_addr > r_hw)) begin
                    r_hw <= r_addr;
                end
            end
            if (i_cmd.load) begin
                r_pend <= 1'b0;
                r_cnt  <= '0;
            end else if (i_cmd.take) begin
                r_pend <= 1'b1;
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_req_data.operation;
            r_dev      <= i_req_data.dev_id;
            r_bind     <= i_req_data.bind_id;
            r_alive_in <= i_req_data.alive_in;
        end
        if (i_cmd.take) begin
            r_pend_slot <= r_addr;
            r_pend_id   <= e_cur.id;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

endmodule

[src/device_registry_table.sv]
// device registry table: one request at a time, scanned one slot per cycle
// unless a waiting result holds the scan; each item is accepted, then its slots
// are visited, the final result loading into the result register at the last
// visit; add goes from slot 1 up, lookups from the high-water slot down to 0
// reset clears the per-slot valid bits at once, so every slot reads free
`timescale 1ns / 1ps

module device_registry_table import drt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drt_req_if.sink   i_req,
    drt_res_if.source o_res
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_req.ready = in_ready;

    drt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    drt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_data (i_req.data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_res)
    );

endmodule
